>>> hw/rtl/hrm_pkg.sv
// Shared types for the hue measure and rebuild pipeline.
package hrm_pkg;

	typedef struct packed {
		logic valid;
		logic chromatic;
	} hrm_ctl_t;

	typedef enum logic [1:0] {
		HIGH_RED,
		HIGH_GREEN,
		HIGH_BLUE
	} hrm_high_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL,
		SEC_YEL_GRN,
		SEC_GRN_CYN,
		SEC_CYN_BLU,
		SEC_BLU_MAG,
		SEC_MAG_RED
	} hrm_sector_t;

endpackage

>>> hw/rtl/rgb_hue_measure_and_rebuild.sv
// Top level: measures the HSV hue of a pixel and rebuilds it at a target hue.
// One request is accepted every cycle while no result is held at the output;
// the hue divider retires one quotient bit per stage.
// The whole pipeline advances together, so a stalled output holds every stage in place.
// Reset clears all valid bits asynchronously; data registers are not reset.
module rgb_hue_measure_and_rebuild import hrm_pkg::*; #(
	parameter int CHANNEL_BITS = 16,
	parameter int HUE_BITS     = 16,
	localparam int S_TDATA_W   = ((3 * CHANNEL_BITS + HUE_BITS + 7) / 8) * 8,
	localparam int M_TDATA_W   = ((3 * CHANNEL_BITS + HUE_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// pixel_red, pixel_green, pixel_blue, target_hue
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// arrived_hue, out_red, out_green, out_blue
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// chromatic
	output logic                 m_axis_tuser
);

	localparam int CB = CHANNEL_BITS;
	localparam int HB = HUE_BITS;
	localparam int DW = CB + 3;
	localparam int DLY = HB - 2;

	logic en;

	// Input unpacking and range search.
	logic signed [CB-1:0] red_in, grn_in, blu_in;
	logic [HB-1:0]        turn_in;
	logic signed [CB-1:0] high_c, low_c;
	hrm_high_t            high_sel_c;
	logic [CB:0]          span_c;

	assign red_in  = s_axis_tdata[0 +: CB];
	assign grn_in  = s_axis_tdata[CB +: CB];
	assign blu_in  = s_axis_tdata[2*CB +: CB];
	assign turn_in = s_axis_tdata[3*CB +: HB];

	always_comb begin
		if (red_in >= grn_in && red_in >= blu_in) begin
			high_sel_c = HIGH_RED;
			high_c     = red_in;
		end else if (grn_in >= blu_in) begin
			high_sel_c = HIGH_GREEN;
			high_c     = grn_in;
		end else begin
			high_sel_c = HIGH_BLUE;
			high_c     = blu_in;
		end
		low_c = red_in;
		if (grn_in < low_c) begin
			low_c = grn_in;
		end
		if (blu_in < low_c) begin
			low_c = blu_in;
		end
		span_c = {high_c[CB-1], high_c} - {low_c[CB-1], low_c};
	end

	logic                 v_s1;
	logic signed [CB-1:0] red_s1, grn_s1, blu_s1;
	logic [HB-1:0]        turn_s1;
	hrm_high_t            high_sel_s1;
	logic [CB-1:0]        low_s1;
	logic [CB-1:0]        range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1      <= red_in;
			grn_s1      <= grn_in;
			blu_s1      <= blu_in;
			turn_s1     <= turn_in;
			high_sel_s1 <= high_sel_c;
			low_s1      <= low_c;
			range_s1    <= span_c[CB-1:0];
		end
	end

	// Hue numerator, divisor and rebuild sector.
	logic signed [CB:0] num_c;
	logic [CB+2:0]      krange_c;
	logic [CB+3:0]      top_c;
	logic [DW-1:0]      dvs_c;
	logic [HB+2:0]      scaled_c;
	logic [HB-1:0]      frac_c;
	logic [HB:0]        factor_c;
	hrm_sector_t        sector_c;

	always_comb begin
		krange_c = '0;
		case (high_sel_s1)
			HIGH_RED: begin
				num_c = {grn_s1[CB-1], grn_s1} - {blu_s1[CB-1], blu_s1};
				if (num_c[CB]) begin
					krange_c = {1'b0, range_s1, 2'b00} + {2'b00, range_s1, 1'b0};
				end
			end
			HIGH_GREEN: begin
				num_c    = {blu_s1[CB-1], blu_s1} - {red_s1[CB-1], red_s1};
				krange_c = {2'b00, range_s1, 1'b0};
			end
			HIGH_BLUE: begin
				num_c    = {red_s1[CB-1], red_s1} - {grn_s1[CB-1], grn_s1};
				krange_c = {1'b0, range_s1, 2'b00};
			end
			default: begin
				num_c = '0;
			end
		endcase
		top_c    = {1'b0, krange_c} + {{3{num_c[CB]}}, num_c};
		dvs_c    = {1'b0, range_s1, 2'b00} + {2'b00, range_s1, 1'b0};
		scaled_c = {1'b0, turn_s1, 2'b00} + {2'b00, turn_s1, 1'b0};
		sector_c = hrm_sector_t'(scaled_c[HB+2:HB]);
		frac_c   = scaled_c[HB-1:0];
		if (scaled_c[HB]) begin
			factor_c = {1'b1, {HB{1'b0}}} - {1'b0, frac_c};
		end else begin
			factor_c = {1'b0, frac_c};
		end
	end

	hrm_ctl_t             ctl_s2;
	logic signed [CB-1:0] red_s2, grn_s2, blu_s2;
	logic [CB-1:0]        low_s2;
	logic [CB-1:0]        range_s2;
	hrm_sector_t          sector_s2;
	logic [HB:0]          factor_s2;
	logic [DW-1:0]        top_s2;
	logic [DW-1:0]        dvs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= '{valid: v_s1, chromatic: (range_s1 != '0)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s2    <= red_s1;
			grn_s2    <= grn_s1;
			blu_s2    <= blu_s1;
			low_s2    <= low_s1;
			range_s2  <= range_s1;
			sector_s2 <= sector_c;
			factor_s2 <= factor_c;
			top_s2    <= top_c[DW-1:0];
			dvs_s2    <= dvs_c;
		end
	end

	// Hue divider runs alongside the rebuild path.
	hrm_ctl_t      div_ctl;
	logic [HB-1:0] div_quo;

	hrm_divider #(
		.DW(DW),
		.QW(HB)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_ctl   (ctl_s2),
		.dividend (top_s2),
		.divisor  (dvs_s2),
		.out_ctl  (div_ctl),
		.quotient (div_quo)
	);

	// Rebuild: the rising channel is chroma scaled by the position in the sector.
	logic [CB+HB:0] prod_c;

	assign prod_c = range_s2 * factor_s2;

	logic signed [CB-1:0] red_s3, grn_s3, blu_s3;
	logic [CB-1:0]        low_s3;
	logic [CB-1:0]        chroma_s3;
	logic [CB-1:0]        rising_s3;
	hrm_sector_t          sector_s3;
	logic                 chrom_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			red_s3    <= red_s2;
			grn_s3    <= grn_s2;
			blu_s3    <= blu_s2;
			low_s3    <= low_s2;
			chroma_s3 <= range_s2;
			rising_s3 <= prod_c[HB +: CB];
			sector_s3 <= sector_s2;
			chrom_s3  <= ctl_s2.chromatic;
		end
	end

	logic [CB-1:0] rr_c, gg_c, bb_c;

	always_comb begin
		rr_c = '0;
		gg_c = '0;
		bb_c = '0;
		case (sector_s3)
			SEC_RED_YEL: begin
				rr_c = chroma_s3;
				gg_c = rising_s3;
			end
			SEC_YEL_GRN: begin
				rr_c = rising_s3;
				gg_c = chroma_s3;
			end
			SEC_GRN_CYN: begin
				gg_c = chroma_s3;
				bb_c = rising_s3;
			end
			SEC_CYN_BLU: begin
				gg_c = rising_s3;
				bb_c = chroma_s3;
			end
			SEC_BLU_MAG: begin
				rr_c = rising_s3;
				bb_c = chroma_s3;
			end
			default: begin
				rr_c = chroma_s3;
				bb_c = rising_s3;
			end
		endcase
	end

	logic [CB-1:0] ored_s4, ogrn_s4, oblu_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ored_s4 <= chrom_s3 ? (low_s3 + rr_c) : red_s3;
			ogrn_s4 <= chrom_s3 ? (low_s3 + gg_c) : grn_s3;
			oblu_s4 <= chrom_s3 ? (low_s3 + bb_c) : blu_s3;
		end
	end

	// Delay line that lines the channels up with the divider output.
	logic [3*CB-1:0] chan_dly_s [DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			chan_dly_s[0] <= {oblu_s4, ogrn_s4, ored_s4};
			for (int j = 1; j < DLY; j++) begin
				chan_dly_s[j] <= chan_dly_s[j-1];
			end
		end
	end

	// Output register.
	logic                   m_tvalid_q;
	logic [HB+3*CB-1:0]     m_tdata_q;
	logic                   m_tuser_q;

	assign en = !m_tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= div_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= {chan_dly_s[DLY-1], (div_ctl.chromatic ? div_quo : {HB{1'b0}})};
			m_tuser_q <= div_ctl.chromatic;
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = M_TDATA_W'(m_tdata_q);
	assign m_axis_tuser  = m_tuser_q;

	// A neutral result always reports a hue of zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[HB-1:0] == '0))
		else $error("neutral result carries a nonzero hue");

	// The pipeline only stalls behind a result that is held at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a held result");

	// The hue numerator stays below the divisor for every chromatic request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.valid && ctl_s2.chromatic) |-> (top_s2 < dvs_s2))
		else $error("hue numerator not below divisor");

endmodule

>>> hw/rtl/hrm_divider.sv
// Pipelined restoring divider that produces one quotient bit per stage.
module hrm_divider import hrm_pkg::*; #(
	parameter int DW = 19,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  hrm_ctl_t      in_ctl,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output hrm_ctl_t      out_ctl,
	output logic [QW-1:0] quotient
);

	// Chromatic dividends stay below the divisor, so their quotients fit QW bits.
	hrm_ctl_t      ctl_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] dvs_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		hrm_ctl_t      ctl_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] dvs_in;
		logic [QW-1:0] quo_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          fits;

		if (i == 0) begin : g_first
			assign ctl_in = in_ctl;
			assign rem_in = dividend;
			assign dvs_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign ctl_in = ctl_s[i-1];
			assign rem_in = rem_s[i-1];
			assign dvs_in = dvs_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {rem_in, 1'b0};
		assign diff  = trial - {1'b0, dvs_in};
		assign fits  = (trial >= {1'b0, dvs_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (en) begin
				ctl_s[i] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= fits ? diff[DW-1:0] : trial[DW-1:0];
				dvs_s[i] <= dvs_in;
				quo_s[i] <= {quo_in[QW-2:0], fits};
			end
		end
	end

	assign out_ctl  = ctl_s[QW-1];
	assign quotient = quo_s[QW-1];

endmodule

>>> test/rgb_hue_measure_and_rebuild_tb.sv
// Testbench for the hue measure and rebuild pipeline, checked against a built-in predictor.
module rgb_hue_measure_and_rebuild_tb import hrm_pkg::*; ();

	localparam int CH_W    = 16;
	localparam int HUE_W   = 16;
	localparam int LATENCY = HUE_W + 3;
	localparam int CH_MAX  = 2 ** (CH_W - 1) - 1;
	localparam int CH_MIN  = -(2 ** (CH_W - 1));
	localparam int N_DIRECTED = 23;

	typedef struct packed {
		logic signed [CH_W-1:0] red;
		logic signed [CH_W-1:0] green;
		logic signed [CH_W-1:0] blue;
		logic [HUE_W-1:0]       hue;
	} pixel_request_t;

	typedef struct packed {
		logic [HUE_W-1:0]       hue;
		logic signed [CH_W-1:0] red;
		logic signed [CH_W-1:0] green;
		logic signed [CH_W-1:0] blue;
		logic                   chromatic;
	} pixel_result_t;

	typedef struct packed {
		pixel_request_t request;
		logic           typed;
		pixel_result_t  result;
	} directed_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [63:0]      s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [63:0]      m_axis_tdata;
	logic             m_axis_tuser;

	pixel_result_t    awaited_results[$];
	int               mismatch_count = 0;
	int               hold_off_cycles = 0;
	bit               burst = 1'b0;
	bit               steady = 1'b0;

	// Rows marked typed carry a result that follows directly from the pixel.
	directed_row_t directed_table [N_DIRECTED] = '{
		'{'{16'sd0, 16'sd0, 16'sd0, 16'h1234}, 1'b1,
			'{16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
		'{'{16'sh8000, 16'sh8000, 16'sh8000, 16'hffff}, 1'b1,
			'{16'd0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0}},
		'{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'h0000}, 1'b1,
			'{16'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0}},
		'{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'h0000}, 1'b1,
			'{16'd0, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1}},
		'{'{16'sh8000, 16'sh7fff, 16'sh8000, 16'h0000}, 1'b1,
			'{16'd21845, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1}},
		'{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'h0000}, 1'b1,
			'{16'd43690, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1}},
		'{'{-16'sd4096, -16'sd4096, -16'sd4096, 16'h8000}, 1'b1,
			'{16'd0, -16'sd4096, -16'sd4096, -16'sd4096, 1'b0}},
		'{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'hffff}, 1'b0, '0},
		'{'{16'sd100, 16'sd0, 16'sd50, 16'h4000}, 1'b0, '0},
		'{'{16'sd1000, 16'sd1000, 16'sd0, 16'd10923}, 1'b0, '0},
		'{'{16'sd1000, -16'sd1000, 16'sd1000, 16'd21846}, 1'b0, '0},
		'{'{-16'sd500, 16'sd700, 16'sd700, 16'd32768}, 1'b0, '0},
		'{'{16'sd4096, 16'sd1024, -16'sd2048, 16'd0}, 1'b0, '0},
		'{'{16'sd4096, 16'sd1024, -16'sd2048, 16'd10923}, 1'b0, '0},
		'{'{16'sd4096, 16'sd1024, -16'sd2048, 16'd21846}, 1'b0, '0},
		'{'{16'sd4096, 16'sd1024, -16'sd2048, 16'd32768}, 1'b0, '0},
		'{'{16'sd4096, 16'sd1024, -16'sd2048, 16'd43691}, 1'b0, '0},
		'{'{16'sd4096, 16'sd1024, -16'sd2048, 16'd54613}, 1'b0, '0},
		'{'{16'sd4096, 16'sd1024, -16'sd2048, 16'hffff}, 1'b0, '0},
		'{'{16'sd1, 16'sd0, 16'sd0, 16'h5555}, 1'b0, '0},
		'{'{16'sd300, 16'sd900, -16'sd100, 16'h2000}, 1'b0, '0},
		'{'{16'sh8000, 16'sd0, 16'sh7fff, 16'h2aab}, 1'b0, '0},
		'{'{16'sh8000, 16'sh7fff, 16'sh7fff, 16'hc000}, 1'b0, '0}
	};

	rgb_hue_measure_and_rebuild #(
		.CHANNEL_BITS(CH_W),
		.HUE_BITS    (HUE_W)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	function automatic pixel_result_t rebuild_at_hue(pixel_request_t rq);
		longint r, g, b, hi, lo, range, k, num, scaled, p, rising, rr, gg, bb;
		int sec_index;
		hrm_high_t top;
		pixel_result_t res;
		r = longint'($signed(rq.red));
		g = longint'($signed(rq.green));
		b = longint'($signed(rq.blue));
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		range = hi - lo;
		if (range == 0) begin
			res.hue = '0;
			res.red = rq.red;
			res.green = rq.green;
			res.blue = rq.blue;
			res.chromatic = 1'b0;
			return res;
		end
		if (hi == r) top = HIGH_RED;
		else if (hi == g) top = HIGH_GREEN;
		else top = HIGH_BLUE;
		case (top)
			HIGH_RED: begin
				num = g - b;
				k = (num < 0) ? 6 : 0;
			end
			HIGH_GREEN: begin
				num = b - r;
				k = 2;
			end
			default: begin
				num = r - g;
				k = 4;
			end
		endcase
		res.hue = HUE_W'(((k * range + num) << HUE_W) / (6 * range));

		scaled = longint'(rq.hue) * 6;
		sec_index = int'(scaled >> HUE_W);
		p = scaled & ((longint'(1) << HUE_W) - 1);
		if (sec_index % 2 == 1) begin
			rising = (range * ((longint'(1) << HUE_W) - p)) >> HUE_W;
		end else begin
			rising = (range * p) >> HUE_W;
		end
		rr = 0;
		gg = 0;
		bb = 0;
		case (hrm_sector_t'(sec_index))
			SEC_RED_YEL: begin rr = range;  gg = rising; end
			SEC_YEL_GRN: begin rr = rising; gg = range;  end
			SEC_GRN_CYN: begin gg = range;  bb = rising; end
			SEC_CYN_BLU: begin gg = rising; bb = range;  end
			SEC_BLU_MAG: begin rr = rising; bb = range;  end
			default:     begin rr = range;  bb = rising; end
		endcase
		res.red = CH_W'(rr + lo);
		res.green = CH_W'(gg + lo);
		res.blue = CH_W'(bb + lo);
		res.chromatic = 1'b1;
		return res;
	endfunction

	function automatic pixel_request_t random_request();
		pixel_request_t rq;
		int ch[3];
		int h;
		int kind;
		kind = $urandom_range(0, 9);
		rq.red = CH_W'($urandom());
		rq.green = CH_W'($urandom());
		rq.blue = CH_W'($urandom());
		rq.hue = HUE_W'($urandom());
		case (kind)
			5: begin
				for (int i = 0; i < 3; i++) begin
					ch[i] = int'($signed(rq.red)) + int'($urandom_range(0, 16)) - 8;
					if (ch[i] > CH_MAX) ch[i] = CH_MAX;
					if (ch[i] < CH_MIN) ch[i] = CH_MIN;
				end
				rq.red = CH_W'(ch[0]);
				rq.green = CH_W'(ch[1]);
				rq.blue = CH_W'(ch[2]);
			end
			6: begin
				rq.green = rq.red;
				rq.blue = rq.red;
			end
			7: begin
				case ($urandom_range(0, 2))
					0: rq.green = rq.red;
					1: rq.blue = rq.red;
					default: rq.blue = rq.green;
				endcase
			end
			8: begin
				for (int i = 0; i < 3; i++) begin
					case ($urandom_range(0, 3))
						0: ch[i] = CH_MAX;
						1: ch[i] = CH_MIN;
						2: ch[i] = 0;
						default: ch[i] = int'($signed(16'($urandom())));
					endcase
				end
				rq.red = CH_W'(ch[0]);
				rq.green = CH_W'(ch[1]);
				rq.blue = CH_W'(ch[2]);
			end
			9: begin
				h = 10923 * int'($urandom_range(0, 6)) + int'($urandom_range(0, 4)) - 2;
				rq.hue = HUE_W'(h);
			end
			default: ;
		endcase
		return rq;
	endfunction

	function automatic int next_gap();
		return (burst || steady) ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < 100) $display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic offer(input pixel_request_t rq, input int gap, input pixel_result_t want);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {rq.hue, rq.blue, rq.green, rq.red};
		do @(posedge clk); while (!s_axis_tready);
		awaited_results.push_back(want);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : receiver
		int stall;
		bit hold_taken;
		hold_taken = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 16);
			if (hold_off_cycles > 0 && !hold_taken) begin
				stall = hold_off_cycles;
				hold_taken = 1'b1;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		pixel_result_t got;
		pixel_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hue = m_axis_tdata[15:0];
			got.red = m_axis_tdata[31:16];
			got.green = m_axis_tdata[47:32];
			got.blue = m_axis_tdata[63:48];
			got.chromatic = m_axis_tuser;
			if (awaited_results.size() == 0) begin
				flag_mismatch("result with no request outstanding");
			end else begin
				want = awaited_results.pop_front();
				if (got.hue !== want.hue)
					flag_mismatch($sformatf("hue got %0d expected %0d", got.hue, want.hue));
				if (got.red !== want.red)
					flag_mismatch($sformatf("red got %0d expected %0d", got.red, want.red));
				if (got.green !== want.green)
					flag_mismatch($sformatf("green got %0d expected %0d",
						got.green, want.green));
				if (got.blue !== want.blue)
					flag_mismatch($sformatf("blue got %0d expected %0d", got.blue, want.blue));
				if (got.chromatic !== want.chromatic)
					flag_mismatch($sformatf("chromatic got %0b expected %0b",
						got.chromatic, want.chromatic));
			end
		end
	end

	initial begin : stimulus
		pixel_request_t rq;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_table[i]) begin
			rq = directed_table[i].request;
			offer(rq, next_gap(),
				directed_table[i].typed ? directed_table[i].result : rebuild_at_hue(rq));
		end

		repeat (300) begin
			rq = random_request();
			offer(rq, next_gap(), rebuild_at_hue(rq));
		end

		// The output side holds off while requests keep coming, so the pipeline backs up.
		hold_off_cycles = 300;
		burst = 1'b1;
		repeat (80) begin
			rq = random_request();
			offer(rq, next_gap(), rebuild_at_hue(rq));
		end
		burst = 1'b0;

		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (awaited_results.size() != 0);

		steady = 1'b1;
		repeat (200) begin
			rq = random_request();
			offer(rq, next_gap(), rebuild_at_hue(rq));
		end
		steady = 1'b0;

		repeat (345) begin
			rq = random_request();
			offer(rq, next_gap(), rebuild_at_hue(rq));
		end

		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
